// File: sv/surs_pkg.sv
// Shared types and constants for the sorted unique resolution set.
// Used by the cell and the top level; depends on nothing.
package surs_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DIM_W           = 16;
	localparam int POS_W           = 6;
	localparam int CNT_OUT_W       = 7;
	localparam int STATUS_W        = 3;

	localparam logic [DIM_W-1:0] RST_MIN_WIDTH  = 16'h0280;
	localparam logic [DIM_W-1:0] RST_MIN_HEIGHT = 16'h01e0;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	localparam logic CFG_MIN_WIDTH  = 1'b0;
	localparam logic CFG_MIN_HEIGHT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED = 3'd0,
		ST_DUP   = 3'd1,
		ST_SMALL = 3'd2,
		ST_QFAIL = 3'd3,
		ST_FULL  = 3'd4,
		ST_READ  = 3'd5,
		ST_RANGE = 3'd6
	} status_t;

	// request travelling along the cell chain
	typedef struct packed {
		logic             vld;
		logic             mode;
		logic             pend;   // still looking for its place or its index
		logic             carry;  // w/h hold a displaced entry
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [POS_W-1:0] ridx;
		status_t          status;
		logic [POS_W-1:0] pos;
		logic [DIM_W-1:0] ow;
		logic [DIM_W-1:0] oh;
	} pkt_t;

	typedef struct packed {
		status_t              status;
		logic [POS_W-1:0]     pos;
		logic [CNT_OUT_W-1:0] cnt;
		logic [DIM_W-1:0]     ow;
		logic [DIM_W-1:0]     oh;
	} res_t;

endpackage

// File: sv/surs_cell.sv
// One cell of the sorted table: holds a single entry and a request register.
// Depends on surs_pkg.
module surs_cell
	import surs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int CELL_IDX    = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pkt_t                               pkt_in,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
	input  logic                               full,
	output pkt_t                               pkt_out
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [DIM_W-1:0] ent_w_q;
	logic [DIM_W-1:0] ent_h_q;
	logic             vld_q;
	pkt_t             pkt_q;
	pkt_t             nxt;
	logic             we;
	logic             ent_v;
	logic             ent_less;
	logic             ent_eq;
	logic             idx_hit;

	assign ent_v    = count > CNT_W'(CELL_IDX);
	assign ent_less = {ent_w_q, ent_h_q} < {pkt_in.w, pkt_in.h};
	assign ent_eq   = {ent_w_q, ent_h_q} == {pkt_in.w, pkt_in.h};
	assign idx_hit  = 32'(pkt_in.ridx) == CELL_IDX;

	always_comb begin
		nxt = pkt_in;
		we  = 1'b0;
		if (pkt_in.vld && pkt_in.pend) begin
			if (pkt_in.mode == MODE_READ) begin
				if (idx_hit) begin
					nxt.pend = 1'b0;
					nxt.pos  = pkt_in.ridx;
					if (ent_v) begin
						nxt.status = ST_READ;
						nxt.ow     = ent_w_q;
						nxt.oh     = ent_h_q;
					end else begin
						nxt.status = ST_RANGE;
					end
				end
			end else if (ent_v && ent_less) begin
				nxt.pend = 1'b1;
			end else if (ent_v && ent_eq) begin
				nxt.pend   = 1'b0;
				nxt.status = ST_DUP;
				nxt.pos    = POS_W'(CELL_IDX);
			end else if (full) begin
				nxt.pend   = 1'b0;
				nxt.status = ST_FULL;
				nxt.pos    = '0;
			end else begin
				// insertion point: take the new pair, push the old entry on
				nxt.pend   = 1'b0;
				nxt.status = ST_ADDED;
				nxt.pos    = POS_W'(CELL_IDX);
				we         = 1'b1;
				nxt.carry  = ent_v;
				nxt.w      = ent_w_q;
				nxt.h      = ent_h_q;
			end
		end else if (pkt_in.vld && pkt_in.carry) begin
			we        = 1'b1;
			nxt.carry = ent_v;
			nxt.w     = ent_w_q;
			nxt.h     = ent_h_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ent_w_q <= pkt_in.w;
			ent_h_q <= pkt_in.h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= pkt_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		pkt_q <= nxt;
	end

	always_comb begin
		pkt_out     = pkt_q;
		pkt_out.vld = vld_q;
	end

endmodule

// File: sv/sorted_unique_resolution_set.sv
// Sorted set of distinct (width, height) pairs with duplicate detection.
// Depends on surs_pkg and surs_cell.
//
// Usage:
//   s_* carries one request: insert a pair (tuser mode 0) or read the entry
//   at read_index (mode 1). m_* returns exactly one result per request, with
//   its status in tuser. cfg_we/cfg_index/cfg_data set min_width (index 0)
//   and min_height (index 1); write them only while no request is open.
//   The table is a chain of TABLE_DEPTH cells, each holding one entry. A
//   request walks the chain one cell per cycle, comparing, inserting and
//   shifting entries up as it goes. Its result is registered in the hold
//   register, then moves into the output register, which drives m_tvalid,
//   once that is empty or taken by the receiver. One request is open at a
//   time; s_tready rises again once its result has moved into the output
//   register, so no new request is taken while one walks the chain.
//   Reset empties the table and sets min_width 640, min_height 480; no
//   clearing pass is needed. If the receiver stalls, the result waits in the
//   output register and one more in the hold register; no request is taken
//   while a result waits in the hold register.
module sorted_unique_resolution_set
	import surs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // width[15:0], height[31:16], read_index[37:32], zero pad
	input  logic [1:0]  s_tuser,   // mode[0], query_failed[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // position[5:0], entry_count[12:6], out_width[28:13],
	                               // out_height[44:29], zero pad
	output logic [2:0]  m_tuser,   // status[2:0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [DIM_W-1:0] min_w_q;
	logic [DIM_W-1:0] min_h_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             hold_v_q;
	res_t             hold_q;
	logic             out_v_q;
	res_t             out_q;

	logic             s_acc;
	logic             full;
	logic             move;
	pkt_t             entry;
	pkt_t             chain [TABLE_DEPTH+1];
	pkt_t             tail;
	status_t          tail_st;
	logic [POS_W-1:0] tail_pos;
	logic [CNT_W-1:0] cnt_nxt;

	assign s_tready = !busy_q;
	assign s_acc    = s_tvalid && s_tready;
	assign full     = count_q == CNT_W'(TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_w_q <= RST_MIN_WIDTH;
			min_h_q <= RST_MIN_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_WIDTH:  min_w_q <= cfg_data;
				CFG_MIN_HEIGHT: min_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// build the request entering cell 0
	always_comb begin
		entry        = '0;
		entry.vld    = s_acc;
		entry.mode   = s_tuser[0];
		entry.w      = s_tdata[15:0];
		entry.h      = s_tdata[31:16];
		entry.ridx   = s_tdata[37:32];
		entry.status = ST_ADDED;
		entry.pend   = 1'b1;
		if (s_tuser[0] == MODE_INSERT) begin
			if (s_tuser[1]) begin
				entry.pend   = 1'b0;
				entry.status = ST_QFAIL;
			end else if (s_tdata[15:0] < min_w_q || s_tdata[31:16] < min_h_q) begin
				entry.pend   = 1'b0;
				entry.status = ST_SMALL;
			end
		end
	end

	assign chain[0] = entry;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		surs_cell #(
			.TABLE_DEPTH (TABLE_DEPTH),
			.CELL_IDX    (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pkt_in  (chain[g]),
			.count   (count_q),
			.full    (full),
			.pkt_out (chain[g+1])
		);
	end

	assign tail = chain[TABLE_DEPTH];

	// finish a request that ran off the end of the chain and work out the new entry count
	always_comb begin
		tail_st  = tail.status;
		tail_pos = tail.pos;
		if (tail.pend) begin
			if (tail.mode == MODE_READ) begin
				tail_st  = ST_RANGE;
				tail_pos = tail.ridx;
			end else begin
				tail_st  = ST_FULL;
				tail_pos = '0;
			end
		end
		cnt_nxt = count_q + CNT_W'(tail_st == ST_ADDED);
	end

	assign move = hold_v_q && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			busy_q   <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (s_acc) begin
				busy_q <= 1'b1;
			end
			if (tail.vld) begin
				count_q  <= cnt_nxt;
				hold_v_q <= 1'b1;
			end
			if (move) begin
				hold_v_q <= 1'b0;
				busy_q   <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.vld) begin
			hold_q.status <= tail_st;
			hold_q.pos    <= tail_pos;
			hold_q.cnt    <= CNT_OUT_W'(cnt_nxt);
			hold_q.ow     <= tail.ow;
			hold_q.oh     <= tail.oh;
		end
		if (move) begin
			out_q <= hold_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {3'b000, out_q.oh, out_q.ow, out_q.cnt, out_q.pos};

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> busy_q)
		else $error("result held with no open request");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (busy_q && !hold_v_q))
		else $error("request left the chain while idle or hold occupied");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_add_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.vld && tail_st == ST_ADDED) |-> !full)
		else $error("pair added to a full table");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !tail.vld) |=> $stable(count_q))
		else $error("entry count moved mid request");

endmodule
